// ===== design/stgl_pkg.sv =====
// ----------------------------------------------------------------------------
// stgl_pkg
// Shared types and constants for the stereogram line engine.
// ----------------------------------------------------------------------------
package stgl_pkg;

    localparam int LW_W  = 11;
    localparam int EW_W  = 10;
    localparam int FR_W  = 8;
    localparam int Z_W   = 8;
    localparam int SEP_W = 10;
    localparam int P_W   = FR_W + Z_W;
    localparam int OMP_W = 17;
    localparam int NUM_W = OMP_W + EW_W;
    localparam int DEN_W = 18;
    localparam int REM_W = NUM_W + 1;
    localparam int CNT_W = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_SEPARATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_RATIO    = 2'd2;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST     = 11'd639;
    localparam logic [EW_W-1:0] EYE_SEPARATION_RST = 10'd188;
    localparam logic [FR_W-1:0] FIELD_RATIO_RST    = 8'd85;

    localparam logic [OMP_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [DEN_W-1:0] TWO_Q16 = 18'd131072;

    typedef struct packed {
        logic [LW_W-1:0] line_width;
        logic [EW_W-1:0] eye_separation;
        logic [FR_W-1:0] field_ratio;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_INIT,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_WRITE
    } back_state_t;

endpackage

// ===== design/random_dot_stereogram_line.sv =====
// ----------------------------------------------------------------------------
// random_dot_stereogram_line
// Single-image stereogram line engine, one colour out per pixel beat in.
// ----------------------------------------------------------------------------
// A pixel beat is accepted only while the front end is idle, so a new beat
// waits until the previous one has been pushed into the queue. The front end
// steps through the r*z product at acceptance, the separation product, the
// divider setup, a 10-step restoring divider for the copy distance and the
// queue push. The back end then does the line store access (registered read,
// then write-back into the output register). A two-entry queue lets the
// divider start the next pixel while the back end or a stalled output holds
// the previous one. Configuration writes are taken at any time but must only
// be issued while no pixel is in flight.
module random_dot_stereogram_line #(
    parameter int MAX_LINE    = 1024,
    parameter int COLOUR_BITS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stgl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stgl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [stgl_pkg::Z_W-1:0]         depth_z,
    input  logic [COLOUR_BITS-1:0]           dot_colour,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [COLOUR_BITS-1:0]           pixel_colour,
    output logic                             line_end
);

    localparam int QW = stgl_pkg::SEP_W + COLOUR_BITS;

    stgl_pkg::cfg_t cfg_reg, cfg_next;

    logic                       push, full, pop, empty;
    logic [stgl_pkg::SEP_W-1:0] push_sep;
    logic [COLOUR_BITS-1:0]     push_dot;
    logic [QW-1:0]              pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                stgl_pkg::CFG_LINE_WIDTH:
                    cfg_next.line_width = cfg_data;
                stgl_pkg::CFG_EYE_SEPARATION:
                    cfg_next.eye_separation = cfg_data[stgl_pkg::EW_W-1:0];
                stgl_pkg::CFG_FIELD_RATIO:
                    cfg_next.field_ratio = cfg_data[stgl_pkg::FR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width     <= stgl_pkg::LINE_WIDTH_RST;
            cfg_reg.eye_separation <= stgl_pkg::EYE_SEPARATION_RST;
            cfg_reg.field_ratio    <= stgl_pkg::FIELD_RATIO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    stgl_front #(
        .COLOUR_BITS (COLOUR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .depth_z    (depth_z),
        .dot_colour (dot_colour),
        .push       (push),
        .full       (full),
        .push_sep   (push_sep),
        .push_dot   (push_dot)
    );

    stgl_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sep, push_dot}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    stgl_back #(
        .MAX_LINE    (MAX_LINE),
        .COLOUR_BITS (COLOUR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (empty),
        .pop          (pop),
        .pop_sep      (pop_data[QW-1:COLOUR_BITS]),
        .pop_dot      (pop_data[COLOUR_BITS-1:0]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_colour (pixel_colour),
        .line_end     (line_end)
    );

endmodule

// ===== design/stgl_front.sv =====
// ----------------------------------------------------------------------------
// stgl_front
// Takes pixel beats and computes the copy distance with a restoring divider.
// ----------------------------------------------------------------------------
module stgl_front #(
    parameter int COLOUR_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stgl_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [stgl_pkg::Z_W-1:0]      depth_z,
    input  logic [COLOUR_BITS-1:0]        dot_colour,
    output logic                          push,
    input  logic                          full,
    output logic [stgl_pkg::SEP_W-1:0]    push_sep,
    output logic [COLOUR_BITS-1:0]        push_dot
);

    stgl_pkg::front_state_t state_reg, state_next;

    logic [stgl_pkg::P_W-1:0]   p_reg, p_next;
    logic [stgl_pkg::NUM_W-1:0] num_reg, num_next;
    logic [stgl_pkg::DEN_W-1:0] den_reg, den_next;
    logic [stgl_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [stgl_pkg::REM_W-1:0] dsh_reg, dsh_next;
    logic [stgl_pkg::SEP_W-1:0] q_reg, q_next;
    logic [stgl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [COLOUR_BITS-1:0]     dot_reg, dot_next;
    logic [stgl_pkg::OMP_W-1:0] one_minus_p;
    logic                       accept;

    assign in_stall    = (state_reg != stgl_pkg::F_IDLE);
    assign accept      = in_valid && !in_stall;
    assign push        = (state_reg == stgl_pkg::F_PUSH) && !full;
    assign push_sep    = q_reg;
    assign push_dot    = dot_reg;
    assign one_minus_p = stgl_pkg::ONE_Q16 - stgl_pkg::OMP_W'(p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stgl_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        dot_reg <= dot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        dot_next   = dot_reg;
        case (state_reg)
            stgl_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    p_next     = stgl_pkg::P_W'(cfg.field_ratio) * stgl_pkg::P_W'(depth_z);
                    dot_next   = dot_colour;
                    state_next = stgl_pkg::F_MUL;
                end
            end
            stgl_pkg::F_MUL:
            begin
                num_next   = stgl_pkg::NUM_W'(one_minus_p)
                           * stgl_pkg::NUM_W'(cfg.eye_separation);
                den_next   = stgl_pkg::TWO_Q16 - stgl_pkg::DEN_W'(p_reg);
                state_next = stgl_pkg::F_INIT;
            end
            stgl_pkg::F_INIT:
            begin
                rem_next   = stgl_pkg::REM_W'({num_reg, 1'b0}) + stgl_pkg::REM_W'(den_reg);
                dsh_next   = stgl_pkg::REM_W'({den_reg, 1'b0}) << (stgl_pkg::SEP_W - 1);
                q_next     = '0;
                cnt_next   = stgl_pkg::CNT_W'(stgl_pkg::SEP_W - 1);
                state_next = stgl_pkg::F_DIV;
            end
            stgl_pkg::F_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[stgl_pkg::SEP_W-2:0], 1'b1};
                end
                else
                begin
                    q_next   = {q_reg[stgl_pkg::SEP_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    state_next = stgl_pkg::F_PUSH;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            stgl_pkg::F_PUSH:
            begin
                if (!full)
                begin
                    state_next = stgl_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = stgl_pkg::F_IDLE;
            end
        endcase
    end

endmodule

// ===== design/stgl_fifo.sv =====
// ----------------------------------------------------------------------------
// stgl_fifo
// Two-entry queue between the divider front and the line store back end.
// ----------------------------------------------------------------------------
module stgl_fifo #(
    parameter int WIDTH = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/stgl_back.sv =====
// ----------------------------------------------------------------------------
// stgl_back
// Column counter, line store lookup and write-back, output register.
// ----------------------------------------------------------------------------
module stgl_back #(
    parameter int MAX_LINE    = 1024,
    parameter int COLOUR_BITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stgl_pkg::cfg_t              cfg,
    input  logic                        empty,
    output logic                        pop,
    input  logic [stgl_pkg::SEP_W-1:0]  pop_sep,
    input  logic [COLOUR_BITS-1:0]      pop_dot,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [COLOUR_BITS-1:0]      pixel_colour,
    output logic                        line_end
);

    localparam int CW   = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
    localparam int XW   = (CW > stgl_pkg::SEP_W) ? CW : stgl_pkg::SEP_W;
    localparam int WDW  = $clog2(MAX_LINE + 1);
    localparam int CMPW = ((WDW > stgl_pkg::LW_W) ? WDW : stgl_pkg::LW_W) + 1;

    stgl_pkg::back_state_t state_reg, state_next;

    logic [COLOUR_BITS-1:0]      store [MAX_LINE];
    logic [COLOUR_BITS-1:0]      rdata_reg;
    logic [COLOUR_BITS-1:0]      dot_reg;
    logic                        use_dot_reg;
    logic [CW-1:0]               col_reg, col_next;
    logic                        out_valid_reg, out_valid_next;
    logic [COLOUR_BITS-1:0]      pixel_colour_reg;
    logic                        line_end_reg;

    logic [stgl_pkg::SEP_W-1:0]  sep0;
    logic                        use_dot;
    logic [CW-1:0]               src;
    logic [COLOUR_BITS-1:0]      colour;
    logic [CMPW-1:0]             x1;
    logic                        last;
    logic                        wr_en;

    assign sep0    = stgl_pkg::SEP_W'(({1'b0, cfg.eye_separation} + 11'd1) >> 1);
    assign use_dot = XW'(col_reg) < XW'(sep0);
    assign src     = (XW'(pop_sep) <= XW'(col_reg))
                   ? CW'(XW'(col_reg) - XW'(pop_sep)) : '0;
    assign pop     = (state_reg == stgl_pkg::B_IDLE) && !empty;
    assign wr_en   = (state_reg == stgl_pkg::B_WRITE) && (!out_valid_reg || !out_stall);
    assign colour  = use_dot_reg ? dot_reg : rdata_reg;
    assign x1      = CMPW'(col_reg) + CMPW'(1);
    assign last    = (x1 >= CMPW'(cfg.line_width)) || (x1 >= CMPW'(MAX_LINE));

    assign out_valid    = out_valid_reg;
    assign pixel_colour = pixel_colour_reg;
    assign line_end     = line_end_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            stgl_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    state_next = stgl_pkg::B_WRITE;
                end
            end
            stgl_pkg::B_WRITE:
            begin
                if (wr_en)
                begin
                    state_next     = stgl_pkg::B_IDLE;
                    col_next       = last ? '0 : CW'(x1);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = stgl_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stgl_pkg::B_IDLE;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rdata_reg   <= store[src];
            dot_reg     <= pop_dot;
            use_dot_reg <= use_dot;
        end
        if (wr_en)
        begin
            store[col_reg]   <= colour;
            pixel_colour_reg <= colour;
            line_end_reg     <= last;
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for random_dot_stereogram_line
// Drives depth/colour pixel beats through the line engine under random input
// gaps and output stalls, predicts each emitted colour and line-end mark from
// its own copy of the line store, column counter and registers, and compares
// every output beat in order. Covers register extremes, clamped widths, zero
// copy distance, width lowered mid-line, a full-width line and a long hold.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH    = 1024;
    localparam int COLOUR_W      = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_PRINTS    = 100;
    localparam int ITEM_COUNT    = 1100;
    localparam int QUIET_ITEMS   = 12;

    localparam logic [stgl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } stereo_pixel_t;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            cfg_valid  = 1'b0;
    logic                            cfg_ready;
    logic [stgl_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [stgl_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [stgl_pkg::Z_W-1:0]        depth_z    = '0;
    logic [COLOUR_W-1:0]             dot_colour = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [COLOUR_W-1:0]             pixel_colour;
    logic                            line_end;

    // predictor state
    logic [stgl_pkg::LW_W-1:0] width_q = stgl_pkg::LINE_WIDTH_RST;
    logic [stgl_pkg::EW_W-1:0] eye_q   = stgl_pkg::EYE_SEPARATION_RST;
    logic [stgl_pkg::FR_W-1:0] ratio_q = stgl_pkg::FIELD_RATIO_RST;
    logic [COLOUR_W-1:0]       store_q [LINE_DEPTH];
    bit                        written_q [LINE_DEPTH];
    int                        col_q   = 0;

    stereo_pixel_t expected_pixels [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int items_sent  = 0;
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;

    random_dot_stereogram_line #(
        .MAX_LINE    (LINE_DEPTH),
        .COLOUR_BITS (COLOUR_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .depth_z      (depth_z),
        .dot_colour   (dot_colour),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_colour (pixel_colour),
        .line_end     (line_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
        begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    // copy distance, round half up
    function automatic int shift_distance(input logic [stgl_pkg::Z_W-1:0] z);
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        p   = 64'(ratio_q) * 64'(z);
        num = (64'd65536 - p) * 64'(eye_q);
        den = 64'd131072 - p;
        return int'((2 * num + den) / (2 * den));
    endfunction

    // store column this pixel copies from, -1 when it takes the dot colour
    function automatic int copy_column(input logic [stgl_pkg::Z_W-1:0] z);
        int sep0;
        int sep;
        sep0 = (int'(eye_q) + 1) / 2;
        if (col_q < sep0)
        begin
            return -1;
        end
        sep = shift_distance(z);
        return (sep <= col_q) ? col_q - sep : 0;
    endfunction

    function automatic void predict_pixel(input logic [stgl_pkg::Z_W-1:0] z,
                                          input logic [COLOUR_W-1:0] c);
        int            src;
        int            wd;
        stereo_pixel_t px;
        src       = copy_column(z);
        px.colour = (src < 0) ? c : store_q[src];
        store_q[col_q]   = px.colour;
        written_q[col_q] = 1'b1;
        if (width_q == '0)
        begin
            wd = 1;
        end
        else if (width_q > LINE_DEPTH)
        begin
            wd = LINE_DEPTH;
        end
        else
        begin
            wd = int'(width_q);
        end
        px.last = (col_q + 1 >= wd);
        col_q   = px.last ? 0 : col_q + 1;
        expected_pixels.push_back(px);
    endfunction

    function automatic logic [stgl_pkg::Z_W-1:0] pick_depth();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return stgl_pkg::Z_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [stgl_pkg::Z_W-1:0] z,
                              input logic [COLOUR_W-1:0] c);
        int src;
        // never read a store entry that was not written since reset
        src = copy_column(z);
        if (src >= 0 && !written_q[src])
        begin
            z = '0;
        end
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        depth_z    <= z;
        dot_colour <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pixel(z, c);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [stgl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stgl_pkg::CFG_DATA_W-1:0] data);
        if (in_valid || expected_pixels.size() != 0)
        begin
            wait_idle();
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            stgl_pkg::CFG_LINE_WIDTH:     width_q = data[stgl_pkg::LW_W-1:0];
            stgl_pkg::CFG_EYE_SEPARATION: eye_q   = data[stgl_pkg::EW_W-1:0];
            stgl_pkg::CFG_FIELD_RATIO:    ratio_q = data[stgl_pkg::FR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [stgl_pkg::LW_W-1:0] w,
                                input logic [stgl_pkg::EW_W-1:0] e,
                                input logic [stgl_pkg::FR_W-1:0] r);
        write_reg(stgl_pkg::CFG_LINE_WIDTH, stgl_pkg::CFG_DATA_W'(w));
        write_reg(stgl_pkg::CFG_EYE_SEPARATION, stgl_pkg::CFG_DATA_W'(e));
        write_reg(stgl_pkg::CFG_FIELD_RATIO, stgl_pkg::CFG_DATA_W'(r));
    endtask

    task automatic test_reset_values();
        send_pixel('0, 4'h0);
        send_pixel('1, 4'hF);
        send_pixel(8'h80, 4'hA);
    endtask

    task automatic test_directed_line();
        logic [stgl_pkg::Z_W-1:0] depths  [8];
        logic [COLOUR_W-1:0]      colours [8];
        depths  = '{8'd0, 8'd255, 8'd128, 8'd0, 8'd128, 8'd1, 8'd200, 8'd64};
        colours = '{4'h0, 4'hF, 4'h5, 4'hA, 4'h3, 4'hC, 4'h9, 4'h6};
        set_geometry(11'd8, 10'd6, 8'd255);
        for (int i = 0; i < 8; i++) send_pixel(depths[i], colours[i]);
        // nearest depth at full ratio: copy distance rounds to zero
        for (int i = 0; i < 8; i++) send_pixel('1, ~colours[i]);
        write_reg(stgl_pkg::CFG_LINE_WIDTH, '0);
        send_pixel(8'd17, 4'h7);
        send_pixel('1, 4'h8);
        write_reg(CFG_UNUSED_INDEX, '1);
        send_pixel('0, 4'h1);
        write_reg(stgl_pkg::CFG_LINE_WIDTH, 11'd8);
        repeat (5) send_pixel(pick_depth(), COLOUR_W'($urandom));
        // width lowered below the current column
        write_reg(stgl_pkg::CFG_LINE_WIDTH, 11'd2);
        send_pixel(8'd40, 4'h2);
        send_pixel(8'd90, 4'hD);
    endtask

    task automatic test_full_width_line();
        set_geometry('1, '1, '1);
        repeat (LINE_DEPTH + 6) send_pixel(pick_depth(), COLOUR_W'($urandom));
    endtask

    task automatic test_output_hold();
        set_geometry(11'd24, 10'd12, 8'd170);
        hold_req = 1'b1;
        repeat (16) send_pixel(pick_depth(), COLOUR_W'($urandom));
        wait_idle();
    endtask

    task automatic test_random_settings();
        int                        n;
        logic [stgl_pkg::LW_W-1:0] w;
        logic [stgl_pkg::EW_W-1:0] e;
        logic [stgl_pkg::FR_W-1:0] r;
        while (items_sent < ITEM_COUNT)
        begin
            case ($urandom_range(0, 9))
                0: w = '0;
                1: w = 11'd1;
                2: w = '1;
                3: w = 11'd1024;
                default: w = stgl_pkg::LW_W'($urandom_range(2, 120));
            endcase
            case ($urandom_range(0, 7))
                0: e = '0;
                1: e = 10'd1;
                2: e = '1;
                default: e = stgl_pkg::EW_W'($urandom_range(2, 90));
            endcase
            case ($urandom_range(0, 5))
                0: r = '0;
                1: r = '1;
                2: r = stgl_pkg::FIELD_RATIO_RST;
                default: r = stgl_pkg::FR_W'($urandom);
            endcase
            idle_on = (items_sent < ITEM_COUNT - QUIET_ITEMS)
                      && ($urandom_range(0, 3) != 0);
            set_geometry(w, e, r);
            n = $urandom_range(4, 10);
            repeat (n) send_pixel(pick_depth(), COLOUR_W'($urandom));
        end
    endtask

    initial
    begin : output_side
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_beat
        stereo_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, pixel_colour %0d line_end %0b",
                                          pixel_colour, line_end));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_colour !== want.colour)
                begin
                    report_mismatch($sformatf("pixel_colour %0d, expected %0d",
                                              pixel_colour, want.colour));
                end
                if (line_end !== want.last)
                begin
                    report_mismatch($sformatf("line_end %0b, expected %0b",
                                              line_end, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR @%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_line();
        test_full_width_line();
        test_output_hold();
        test_random_settings();
        wait_idle();
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
